### sv/lae_pkg.sv
// Shared types and constants of the life automaton engine.
package lae_pkg;

   localparam int GRID_COLS_DEF = 128;
   localparam int GRID_ROWS_DEF = 128;
   localparam int CMD_W         = 3;
   localparam int COORD_W       = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_STEP   = 3'd0,
      CMD_TOGGLE = 3'd1,
      CMD_WRITE  = 3'd2,
      CMD_READ   = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

endpackage

### sv/lae_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/life_automaton_engine_unit.sv
// Toroidal Game of Life engine: row-wide ping-pong plane memories and a cell sequencer.
// Step: one neighbor count per cycle from three row registers, rows fetched from the
//   current plane RAM, written to the other.
// Toggle, write, read: read-modify-write of one row; out of range: answered from idle.
// Clear: one row per cycle. busy is high for the whole of every request that leaves idle.
// Reset runs the same clearing pass with busy high; no response is given.
// One response strobe per request, in the same cycle that busy falls; it cannot be stalled.
module life_automaton_engine_unit
   import lae_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF,
   parameter int GRID_ROWS = GRID_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row,
   input  logic               req_wr_value,
   output logic               rsp_strobe,
   output logic               rsp_cell_value
);

   localparam int COL_W = $clog2(GRID_COLS);
   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_RMW_RD,
      S_RMW_WR,
      S_FILL,
      S_CELL,
      S_ROWEND
   } state_type;

   state_type            state_ff, state_in;
   logic                 bank_ff, bank_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [1:0]           fill_ff, fill_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic                 wv_ff, wv_in;
   logic                 clr_ack_ff, clr_ack_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_value_ff, rsp_value_in;
   logic [GRID_COLS-1:0] up_ff, up_in;
   logic [GRID_COLS-1:0] mid_ff, mid_in;
   logic [GRID_COLS-1:0] down_ff, down_in;
   logic [GRID_COLS-1:0] ahead_ff, ahead_in;
   logic [GRID_COLS-1:0] new_ff, new_in;

   logic                 rd_en;
   logic [ROW_W-1:0]     rd_addr;
   logic [GRID_COLS-1:0] rd_row0, rd_row1, rd_row;
   logic                 wr_en, wr_bank;
   logic [ROW_W-1:0]     wr_addr;
   logic [GRID_COLS-1:0] wr_data;

   logic [COL_W-1:0]     col_l, col_r;
   logic [3:0]           ncount;
   logic                 life_bit;
   logic [ROW_W:0]       ahead_sum;
   logic [ROW_W-1:0]     ahead_row;
   logic                 in_range, old_bit, mod_bit;

   lae_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_plane0 (
      .clock   (clock),
      .wr_en   (wr_en && !wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_row0)
   );

   lae_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_plane1 (
      .clock   (clock),
      .wr_en   (wr_en && wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_row1)
   );

   assign rd_row = bank_ff ? rd_row1 : rd_row0;

   // neighbor count for the cell at col_ff of the middle row
   always_comb begin
      col_l  = (col_ff == '0) ? COL_LAST : col_ff - COL_W'(1);
      col_r  = (col_ff == COL_LAST) ? '0 : col_ff + COL_W'(1);
      ncount = 4'(up_ff[col_l]) + 4'(up_ff[col_ff]) + 4'(up_ff[col_r])
             + 4'(mid_ff[col_l]) + 4'(mid_ff[col_r])
             + 4'(down_ff[col_l]) + 4'(down_ff[col_ff]) + 4'(down_ff[col_r]);
      life_bit = (ncount == 4'd3) || (mid_ff[col_ff] && ncount == 4'd2);
      ahead_sum = {1'b0, row_ff} + (ROW_W+1)'(2);
      ahead_row = (ahead_sum >= (ROW_W+1)'(GRID_ROWS))
                ? ROW_W'(ahead_sum - (ROW_W+1)'(GRID_ROWS)) : ROW_W'(ahead_sum);
      in_range = (32'(req_col) < GRID_COLS) && (32'(req_row) < GRID_ROWS);
      old_bit  = rd_row[col_ff];
      if (cmd_ff == CMD_TOGGLE) begin
         mod_bit = !old_bit;
      end else if (cmd_ff == CMD_WRITE) begin
         mod_bit = wv_ff;
      end else begin
         mod_bit = old_bit;
      end
   end

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      fill_in       = fill_ff;
      cmd_in        = cmd_ff;
      wv_in         = wv_ff;
      clr_ack_in    = clr_ack_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = 1'b0;
      up_in         = up_ff;
      mid_in        = mid_ff;
      down_in       = down_ff;
      ahead_in      = ahead_ff;
      new_in        = new_ff;
      rd_en         = 1'b0;
      rd_addr       = row_ff;
      wr_en         = 1'b0;
      wr_bank       = bank_ff;
      wr_addr       = row_ff;
      wr_data       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd;
               wv_in  = req_wr_value;
               if (req_cmd == CMD_STEP) begin
                  fill_in  = '0;
                  state_in = S_FILL;
               end else if (req_cmd == CMD_CLEAR) begin
                  row_in     = '0;
                  clr_ack_in = 1'b1;
                  state_in   = S_CLEAR;
               end else if (in_range && (req_cmd == CMD_TOGGLE || req_cmd == CMD_WRITE
                                         || req_cmd == CMD_READ)) begin
                  row_in   = ROW_W'(req_row);
                  col_in   = COL_W'(req_col);
                  state_in = S_RMW_RD;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         S_CLEAR: begin
            wr_en = 1'b1;
            if (row_ff == ROW_LAST) begin
               rsp_strobe_in = clr_ack_ff;
               state_in      = S_IDLE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         S_RMW_RD: begin
            rd_en    = 1'b1;
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            wr_en          = (cmd_ff != CMD_READ);
            wr_data        = rd_row;
            wr_data[col_ff] = mod_bit;
            rsp_strobe_in  = 1'b1;
            rsp_value_in   = mod_bit;
            state_in       = S_IDLE;
         end
         S_FILL: begin
            // prefetch rows last, 0 and 1 into the window
            fill_in = fill_ff + 2'd1;
            unique case (fill_ff)
               2'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = ROW_LAST;
               end
               2'd1: begin
                  up_in   = rd_row;
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end
               2'd2: begin
                  mid_in  = rd_row;
                  rd_en   = 1'b1;
                  rd_addr = ROW_W'(1);
               end
               default: begin
                  down_in  = rd_row;
                  row_in   = '0;
                  col_in   = '0;
                  state_in = S_CELL;
               end
            endcase
         end
         S_CELL: begin
            if (col_ff == '0) begin
               rd_en   = 1'b1;
               rd_addr = ahead_row;
            end
            if (col_ff == COL_W'(1)) begin
               ahead_in = rd_row;
            end
            new_in = {life_bit, new_ff[GRID_COLS-1:1]};
            if (col_ff == COL_LAST) begin
               state_in = S_ROWEND;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         S_ROWEND: begin
            wr_en   = 1'b1;
            wr_bank = !bank_ff;
            wr_data = new_ff;
            up_in   = mid_ff;
            mid_in  = down_ff;
            down_in = ahead_ff;
            col_in  = '0;
            if (row_ff == ROW_LAST) begin
               bank_in       = !bank_ff;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = S_CELL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         bank_ff       <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         fill_ff       <= '0;
         clr_ack_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_value_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         fill_ff       <= fill_in;
         clr_ack_ff    <= clr_ack_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_value_ff  <= rsp_value_in;
      end
      cmd_ff   <= cmd_in;
      wv_ff    <= wv_in;
      up_ff    <= up_in;
      mid_ff   <= mid_in;
      down_ff  <= down_in;
      ahead_ff <= ahead_in;
      new_ff   <= new_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_value = rsp_value_ff;

endmodule
